// ----- design/kf442_pkg.sv -----
// ----------------------------------------------------------------------------
// kf442_pkg: shared constants for the *442 kaleidoscope fold
// Field widths of the register and result coordinates, register map and
// the remainder pipeline step size.
// ----------------------------------------------------------------------------
`default_nettype none

package kf442_pkg;

  // mirror_size register width (unsigned Q14.16)
  localparam int unsigned SIZE_W = 30;
  // folded coordinate width (signed Q15.16)
  localparam int unsigned OUT_W = 31;
  // partial remainder width: holds up to twice the largest size, shifted once
  localparam int unsigned REM_W = SIZE_W + 2;
  // dividend bits retired per remainder stage
  localparam int unsigned BPS = 2;

  // reset value of mirror_size (1.0 in Q16.16)
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);
  // invalid pixel marker, in whole units
  localparam int unsigned MARKER_UNITS = 1000;

  // APB register map
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MIRROR_SIZE = 1'b0;

  // folded point on its way to the output register
  typedef struct packed {
    logic              vld;
    logic              inv;
    logic              par;
    logic [SIZE_W-1:0] x;
    logic [SIZE_W-1:0] y;
  } fold_t;

endpackage

`default_nettype wire

// ----- design/kaleidoscope_fold_442.sv -----
// ----------------------------------------------------------------------------
// kaleidoscope_fold_442: fold map pixels into the *442 fundamental triangle
// Mirrors each point at 0, reduces it modulo twice the cell size, mirrors
// at size and at the diagonal, tracking parity; pipelined remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one pixel per transfer, coordinates in signed
//   Q16.16, a pixel valid flag and the incoming parity. Accepted when
//   in_valid is high and in_stall is low.
//   Output channel (out_*): one folded point per input, in input order,
//   taken when out_valid is high and out_stall is low.
//   Config (cfg_*): APB port, mirror_size at byte address 0. Write it only
//   while no pixel is in flight. A size of 0 folds as the least size.
// Throughput: one pixel per cycle unless stalled. Depth: (COORD_WIDTH+1)/2 + 3
//   register stages, 19 at the default width: stage 0, the remainder stages,
//   the fold stage and the output register. The depth is set by the
//   restoring remainder pipeline, which retires two dividend bits per stage
//   for both axes.
// Stall: the whole pipeline holds while the output register is full and
//   out_stall is high; in_stall is raised in the same cycle. Bubbles stay.
// Reset: rst_n (synchronous, low) empties the pipeline and restores
//   mirror_size to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module kaleidoscope_fold_442 #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]        in_x_in,
  input  wire logic signed [COORD_WIDTH-1:0]        in_y_in,
  input  wire logic                                 in_pixel_valid,
  input  wire logic                                 in_parity_in,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [kf442_pkg::OUT_W-1:0]        out_fold_x,
  output logic signed [kf442_pkg::OUT_W-1:0]        out_fold_y,
  output logic                                      out_parity_out,
  output logic                                      out_pixel_invalid,
  // configuration port
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [kf442_pkg::ADDR_W-1:0]         cfg_paddr,
  input  wire logic [31:0]                          cfg_pwdata,
  output logic [31:0]                               cfg_prdata,
  output logic                                      cfg_pready
);

  import kf442_pkg::*;

  localparam int NSTG = (COORD_WIDTH + BPS - 1) / BPS;
  localparam int DW   = NSTG * BPS;
  localparam logic [63:0] MARK_FULL = 64'd0 - (64'(MARKER_UNITS) << FRAC_BITS);
  localparam logic [OUT_W-1:0] MARKER = MARK_FULL[OUT_W-1:0];

  // remainder pipeline stage
  typedef struct packed {
    logic             vld;
    logic             inv;
    logic             par;
    logic [DW-1:0]    dx;
    logic [DW-1:0]    dy;
    logic [REM_W-1:0] rx;
    logic [REM_W-1:0] ry;
  } div_t;

  // one restoring step per dividend bit, MSB first
  function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] rem,
                                                input logic [BPS-1:0]   bits,
                                                input logic [REM_W-1:0] dvs);
    logic [REM_W-1:0] t;
    t = rem;
    for (int i = BPS - 1; i >= 0; i--) begin
      t = {t[REM_W-2:0], bits[i]};
      if (t >= dvs) begin
        t = t - dvs;
      end
    end
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] mirror_size_r;
  logic [SIZE_W-1:0] size_eff_r;
  logic [SIZE_W-1:0] wr_size;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                   (cfg_paddr[2] == REG_MIRROR_SIZE);
  assign wr_size = cfg_pwdata[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_size_r <= SIZE_RESET;
      size_eff_r    <= SIZE_RESET;
    end else if (cfg_wr) begin
      mirror_size_r <= wr_size;
      size_eff_r    <= (wr_size == '0) ? SIZE_W'(1) : wr_size;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MIRROR_SIZE) begin
      cfg_prdata = 32'(mirror_size_r);
    end
  end

  // divisor: twice the effective size
  logic [REM_W-1:0] twice;
  assign twice = REM_W'({size_eff_r, 1'b0});

  // --------------------------------------------------------------------------
  // pipeline advance: everything moves unless the output register is held
  // --------------------------------------------------------------------------
  logic adv;
  logic out_vld_r;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // stage 0: magnitudes, parity of the mirrors at 0
  // --------------------------------------------------------------------------
  div_t             st_r [NSTG+1];
  div_t             st0_nxt;
  logic [COORD_WIDTH-1:0] mag_x;
  logic [COORD_WIDTH-1:0] mag_y;

  always_comb begin
    mag_x = in_x_in[COORD_WIDTH-1] ? (~in_x_in + 1'b1) : in_x_in;
    mag_y = in_y_in[COORD_WIDTH-1] ? (~in_y_in + 1'b1) : in_y_in;
    st0_nxt.vld = in_valid;
    st0_nxt.inv = !in_pixel_valid;
    st0_nxt.par = in_parity_in ^ in_x_in[COORD_WIDTH-1] ^ in_y_in[COORD_WIDTH-1];
    st0_nxt.dx  = DW'(mag_x);
    st0_nxt.dy  = DW'(mag_y);
    st0_nxt.rx  = '0;
    st0_nxt.ry  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else if (adv) begin
      st_r[0] <= st0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // remainder stages: BPS dividend bits per stage for both axes
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    div_t st_nxt;

    always_comb begin
      st_nxt    = st_r[k];
      st_nxt.rx = rem_step(st_r[k].rx, st_r[k].dx[DW-1-BPS*k -: BPS], twice);
      st_nxt.ry = rem_step(st_r[k].ry, st_r[k].dy[DW-1-BPS*k -: BPS], twice);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1].vld <= 1'b0;
      end else if (adv) begin
        st_r[k+1] <= st_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // fold stage: mirror at size when the remainder lies past it
  // --------------------------------------------------------------------------
  fold_t            fold_r;
  fold_t            fold_nxt;
  logic             px_far;
  logic             py_far;
  logic [REM_W-1:0] rx_m;
  logic [REM_W-1:0] ry_m;

  always_comb begin
    px_far = st_r[NSTG].rx > REM_W'(size_eff_r);
    py_far = st_r[NSTG].ry > REM_W'(size_eff_r);
    rx_m   = px_far ? (twice - st_r[NSTG].rx) : st_r[NSTG].rx;
    ry_m   = py_far ? (twice - st_r[NSTG].ry) : st_r[NSTG].ry;
    fold_nxt.vld = st_r[NSTG].vld;
    fold_nxt.inv = st_r[NSTG].inv;
    fold_nxt.par = st_r[NSTG].par ^ px_far ^ py_far;
    fold_nxt.x   = rx_m[SIZE_W-1:0];
    fold_nxt.y   = ry_m[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r.vld <= 1'b0;
    end else if (adv) begin
      fold_r <= fold_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output register: diagonal mirror, invalid pixel marker
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0] fx_r, fx_nxt;
  logic [OUT_W-1:0] fy_r, fy_nxt;
  logic             par_r, par_nxt;
  logic             inv_r;
  logic             swap;

  always_comb begin
    swap = fold_r.y > fold_r.x;
    if (fold_r.inv) begin
      fx_nxt  = MARKER;
      fy_nxt  = MARKER;
      par_nxt = 1'b0;
    end else begin
      fx_nxt  = OUT_W'(swap ? fold_r.y : fold_r.x);
      fy_nxt  = OUT_W'(swap ? fold_r.x : fold_r.y);
      par_nxt = fold_r.par ^ swap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fold_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_r  <= fx_nxt;
      fy_r  <= fy_nxt;
      par_r <= par_nxt;
      inv_r <= fold_r.inv;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_fold_x        = fx_r;
  assign out_fold_y        = fy_r;
  assign out_parity_out    = par_r;
  assign out_pixel_invalid = inv_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  // folded point lies in the triangle
  a_tri_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel_invalid) |-> (out_fold_y <= out_fold_x && !out_fold_y[OUT_W-1]))
    else $error("folded y exceeds folded x");

  a_tri_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel_invalid) |-> (out_fold_x <= OUT_W'(size_eff_r)))
    else $error("folded x exceeds mirror size");

  // invalid pixels carry the marker and zero parity
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_invalid) |->
      (out_fold_x == MARKER && out_fold_y == MARKER && !out_parity_out))
    else $error("invalid pixel result malformed");

  // input is held off only by a blocked output register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // a held result does not move while the pipeline is frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_fold_x) && $stable(out_fold_y)))
    else $error("held result changed");
`endif

endmodule

`default_nettype wire
